>>> rtl/button_gesture_classifier_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the button gesture classifier
// Concurrent checks clocked on clk and held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_MACROS_SVH

// Same-cycle implication.
`define BGC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bgc: same-cycle check failed");

// Next-cycle implication.
`define BGC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bgc: next-cycle check failed");

`endif

>>> rtl/bgc_pkg.sv
// ---------------------------------------------------------------------------
// bgc_pkg
// Types and constants shared by the button gesture classifier modules.
// ---------------------------------------------------------------------------
package bgc_pkg;

  localparam int TDATA_IN_W  = 40;
  localparam int TDATA_OUT_W = 8;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // Operation codes carried on s_tuser.
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Button levels.
  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_LONG_PRESS = 1'b0;
  localparam logic REG_CLICK_GAP  = 1'b1;

  localparam logic [15:0] LONG_PRESS_RESET = 16'd250;
  localparam logic [15:0] CLICK_GAP_RESET  = 16'd150;

  // Gesture codes.
  localparam logic [1:0] G_CLICK   = 2'd0;
  localparam logic [1:0] G_DOUBLE  = 2'd1;
  localparam logic [1:0] G_LONG    = 2'd2;
  localparam logic [1:0] G_LONGREL = 2'd3;

  typedef enum logic [6:0] {
    ST_IDLE        = 7'b0000001,
    ST_FIRST_DOWN  = 7'b0000010,
    ST_FIRST_UP    = 7'b0000100,
    ST_SECOND_DOWN = 7'b0001000,
    ST_SECOND_UP   = 7'b0010000,
    ST_LONG_PRESS  = 7'b0100000,
    ST_RELEASE     = 7'b1000000
  } gesture_state_t;

  typedef struct packed {
    gesture_state_t gesture_state;
    logic           last_level;
    logic [31:0]    press_stamp;
    logic [31:0]    release_stamp;
  } bgc_state_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] gesture;
  } bgc_result_t;

endpackage

>>> rtl/bgc_core.sv
// ---------------------------------------------------------------------------
// bgc_core
// Next-state and gesture logic for one accepted report or poll tick.
// ---------------------------------------------------------------------------
module bgc_core (
  input  bgc_pkg::bgc_state_t  cur,
  input  logic                 operation,
  input  logic                 level,
  input  logic [31:0]          now_ms,
  input  logic [15:0]          long_press_ms,
  input  logic [15:0]          click_gap_ms,
  output bgc_pkg::bgc_state_t  nxt,
  output bgc_pkg::bgc_result_t res
);
  import bgc_pkg::*;

  logic [31:0] held_ms;
  logic [31:0] gap_ms;
  logic        long_hit;
  logic        gap_hit;

  // Elapsed times wrap modulo 2^32 with the timestamp.
  assign held_ms  = now_ms - cur.press_stamp;
  assign gap_ms   = now_ms - cur.release_stamp;
  assign long_hit = held_ms > {16'd0, long_press_ms};
  assign gap_hit  = gap_ms > {16'd0, click_gap_ms};

  always_comb begin
    nxt         = cur;
    res.emit    = 1'b0;
    res.gesture = G_CLICK;
    if (operation == OP_REPORT) begin
      if (level != cur.last_level) begin
        nxt.last_level = level;
        if (level == LVL_RELEASED) begin
          nxt.release_stamp = now_ms;
          case (cur.gesture_state)
            ST_FIRST_DOWN:  nxt.gesture_state = ST_FIRST_UP;
            ST_SECOND_DOWN: nxt.gesture_state = ST_SECOND_UP;
            ST_LONG_PRESS:  nxt.gesture_state = ST_RELEASE;
            default: ;
          endcase
        end else begin
          nxt.press_stamp = now_ms;
          case (cur.gesture_state)
            ST_IDLE:     nxt.gesture_state = ST_FIRST_DOWN;
            ST_FIRST_UP: nxt.gesture_state = ST_SECOND_DOWN;
            default: ;
          endcase
        end
      end
    end else begin
      case (cur.gesture_state)
        ST_FIRST_DOWN, ST_SECOND_DOWN: begin
          if (long_hit) begin
            nxt.gesture_state = ST_LONG_PRESS;
            res.emit          = 1'b1;
            res.gesture       = G_LONG;
          end
        end
        ST_FIRST_UP: begin
          if (gap_hit) begin
            nxt.gesture_state = ST_IDLE;
            res.emit          = 1'b1;
            res.gesture       = G_CLICK;
          end
        end
        ST_SECOND_UP: begin
          nxt.gesture_state = ST_IDLE;
          res.emit          = 1'b1;
          res.gesture       = G_DOUBLE;
        end
        ST_RELEASE: begin
          nxt.gesture_state = ST_IDLE;
          res.emit          = 1'b1;
          res.gesture       = G_LONGREL;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/button_gesture_classifier.sv
// ---------------------------------------------------------------------------
// button_gesture_classifier
// Turns button level reports and poll ticks into click, double click,
// long press and long press release gestures.
// ---------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         tuser: operation; tdata: level, now_ms
//  m_*       out        tdata: gesture
//  APB       in/out     long_press_ms at 0x0, click_gap_ms at 0x4
//
// One request is taken per clock while s_tready is high; its gesture, if any,
// shows on m_* the following cycle from the result register.
// The state and stamp registers update in the same edge that takes the
// request, so the next request sees them at once.
// A waiting gesture stalls input only while m_tready is low.
// rst is synchronous and restores the state and both thresholds.
// ---------------------------------------------------------------------------
`include "button_gesture_classifier_macros.svh"

module button_gesture_classifier (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: [0] level, [32:1] now_ms, [39:33] zero
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bgc_pkg::TDATA_IN_W-1:0]     s_tdata,
  // s_tuser: [0] operation
  input  logic                               s_tuser,
  // m_tdata: [1:0] gesture, [7:2] zero
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bgc_pkg::TDATA_OUT_W-1:0]    m_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bgc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bgc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bgc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import bgc_pkg::*;

  bgc_state_t  state;
  bgc_state_t  state_next;
  bgc_result_t res;
  logic [15:0] long_press_ms;
  logic [15:0] click_gap_ms;
  logic [1:0]  gesture;
  logic        s_accept;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == REG_CLICK_GAP) ? {16'd0, click_gap_ms}
                                                 : {16'd0, long_press_ms};

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LONG_PRESS_RESET;
      click_gap_ms  <= CLICK_GAP_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_LONG_PRESS) begin
        long_press_ms <= pwdata[15:0];
      end else begin
        click_gap_ms <= pwdata[15:0];
      end
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  bgc_core u_core (
    .cur           (state),
    .operation     (s_tuser),
    .level         (s_tdata[0]),
    .now_ms        (s_tdata[32:1]),
    .long_press_ms (long_press_ms),
    .click_gap_ms  (click_gap_ms),
    .nxt           (state_next),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.gesture_state <= ST_IDLE;
      state.last_level    <= LVL_RELEASED;
      state.press_stamp   <= 32'd0;
      state.release_stamp <= 32'd0;
    end else if (s_accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_accept && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && res.emit) begin
      gesture <= res.gesture;
    end
  end

  assign m_tdata = {{(TDATA_OUT_W - 2){1'b0}}, gesture};

  `BGC_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)
  `BGC_ASSERT_NEXT(a_report_no_gesture, s_accept && s_tuser == OP_REPORT, !m_tvalid)
  `BGC_ASSERT_NEXT(a_double_click,
    s_accept && s_tuser == OP_TICK && state.gesture_state == ST_SECOND_UP,
    m_tvalid && gesture == G_DOUBLE && state.gesture_state == ST_IDLE)
  `BGC_ASSERT_NEXT(a_repeat_level_ignored,
    s_accept && s_tuser == OP_REPORT && s_tdata[0] == state.last_level,
    $stable(state))

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Button gesture classifier testbench
// Drives level reports and poll ticks over the input stream and checks every
// gesture on the output stream against a cycle-free predictor of the gesture
// state machine. The thresholds are reprogrammed over APB between phases,
// and both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;
  import bgc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int NUM_PHASES = 6;
  localparam int SETTLE_CYCLES = 4;

  // Predicts the gestures from the accepted requests and checks each result.
  class gesture_scoreboard;
    gesture_state_t state = ST_IDLE;
    logic last_level = LVL_RELEASED;
    logic [31:0] press_stamp = '0;
    logic [31:0] release_stamp = '0;
    logic [15:0] long_press_ms = LONG_PRESS_RESET;
    logic [15:0] click_gap_ms = CLICK_GAP_RESET;
    logic [1:0] gesture_q[$];
    int unsigned errors = 0;

    function void set_threshold(logic idx, logic [15:0] value);
      if (idx == REG_LONG_PRESS) long_press_ms = value;
      else click_gap_ms = value;
    endfunction

    function void note_event(logic op, logic lvl, logic [31:0] now);
      logic [31:0] held;
      logic [31:0] gap;
      held = now - press_stamp;
      gap = now - release_stamp;
      if (op == OP_REPORT) begin
        if (lvl == last_level) return;
        last_level = lvl;
        if (lvl == LVL_RELEASED) begin
          release_stamp = now;
          case (state)
            ST_FIRST_DOWN: state = ST_FIRST_UP;
            ST_SECOND_DOWN: state = ST_SECOND_UP;
            ST_LONG_PRESS: state = ST_RELEASE;
            default: ;
          endcase
        end else begin
          press_stamp = now;
          case (state)
            ST_IDLE: state = ST_FIRST_DOWN;
            ST_FIRST_UP: state = ST_SECOND_DOWN;
            default: ;
          endcase
        end
      end else begin
        case (state)
          ST_FIRST_DOWN, ST_SECOND_DOWN: begin
            if (held > {16'd0, long_press_ms}) begin
              state = ST_LONG_PRESS;
              gesture_q.push_back(G_LONG);
            end
          end
          ST_FIRST_UP: begin
            if (gap > {16'd0, click_gap_ms}) begin
              state = ST_IDLE;
              gesture_q.push_back(G_CLICK);
            end
          end
          ST_SECOND_UP: begin
            state = ST_IDLE;
            gesture_q.push_back(G_DOUBLE);
          end
          ST_RELEASE: begin
            state = ST_IDLE;
            gesture_q.push_back(G_LONGREL);
          end
          default: ;
        endcase
      end
    endfunction

    function void check_gesture(logic [TDATA_OUT_W-1:0] tdata);
      logic [1:0] want;
      if (gesture_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected gesture %0d, none pending", $realtime, tdata[1:0]);
        return;
      end
      want = gesture_q.pop_front();
      if (tdata[1:0] !== want) begin
        errors++;
        if (errors <= 10)
          $display("%0t: gesture mismatch, expected %0d, got %0d",
                   $realtime, want, tdata[1:0]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_IN_W-1:0] s_tdata = '0;
  logic s_tuser = OP_REPORT;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  gesture_scoreboard board = new();
  bit src_no_stall = 1'b0;
  bit sink_no_stall = 1'b0;
  int unsigned sink_wait = 0;
  int unsigned idle_cycles = 0;
  int unsigned req_count = 0;
  logic [31:0] stamp_clock = '0;
  logic btn_level = LVL_RELEASED;

  button_gesture_classifier DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: after each gesture the sink draws how long it stays not ready.
  always @(posedge clk) begin : gesture_sink
    int unsigned hold;
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      board.check_gesture(m_tdata);
      hold = sink_no_stall ? 0 : $urandom_range(0, 12);
      sink_wait <= hold;
      m_tready <= (hold == 0);
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      m_tready <= (sink_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** button_gesture_classifier: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Valid is only lowered when a gap follows, so it never toggles within a step.
  task automatic push_request(input logic op, input logic lvl, input logic [31:0] now);
    int unsigned gap;
    gap = src_no_stall ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(TDATA_IN_W - 33){1'b0}}, now, lvl};
    do @(posedge clk); while (!s_tready);
    board.note_event(op, lvl, now);
    req_count++;
  endtask

  task automatic drain_gestures();
    s_tvalid <= 1'b0;
    while (board.gesture_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_threshold(idx, value);
  endtask

  // Occasional noise: repeated levels, ticks and reports at arbitrary times.
  task automatic send_item(input logic op, input logic lvl, input int unsigned dt);
    logic noise_lvl;
    stamp_clock += dt;
    if (op == OP_REPORT) btn_level = lvl;
    push_request(op, lvl, stamp_clock);
    if ($urandom_range(0, 99) < 8) begin
      noise_lvl = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 2))
        0: push_request(OP_REPORT, btn_level, stamp_clock + $urandom_range(0, 3));
        1: push_request(OP_TICK, noise_lvl, $urandom());
        default: begin
          btn_level = noise_lvl;
          push_request(OP_REPORT, noise_lvl, $urandom());
        end
      endcase
    end
  endtask

  // A duration below, at, just past or well past a threshold.
  function automatic int unsigned pick_span(input int unsigned thr);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, thr);
      1: return thr;
      2: return thr + 1;
      default: return thr + $urandom_range(1, thr + 16);
    endcase
  endfunction

  // Polls a few times within the span, often landing exactly on its end.
  task automatic poll_through(input int unsigned span);
    int unsigned used;
    int unsigned step;
    used = 0;
    repeat ($urandom_range(0, 3)) begin
      step = $urandom_range(0, span - used);
      used += step;
      send_item(OP_TICK, 1'($urandom_range(0, 1)), step);
    end
    if ($urandom_range(0, 1)) send_item(OP_TICK, 1'($urandom_range(0, 1)), span - used);
    else stamp_clock += span - used;
  endtask

  task automatic play_gesture();
    repeat ($urandom_range(1, 3)) begin
      send_item(OP_REPORT, LVL_PRESSED, $urandom_range(0, 2));
      poll_through(pick_span(32'(board.long_press_ms)));
      send_item(OP_REPORT, LVL_RELEASED, 0);
      poll_through(pick_span(32'(board.click_gap_ms)));
    end
    send_item(OP_TICK, 1'($urandom_range(0, 1)), pick_span(32'(board.click_gap_ms)));
  endtask

  initial begin : stimulus
    logic [15:0] lp;
    logic [15:0] cg;
    int unsigned sent;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset thresholds.
    push_request(OP_TICK, LVL_RELEASED, 32'd0);
    push_request(OP_REPORT, LVL_RELEASED, 32'd5);
    push_request(OP_REPORT, LVL_PRESSED, 32'hFFFF_FFFF);
    push_request(OP_TICK, LVL_RELEASED, 32'h0000_00F9);  // held exactly 250 across the wrap
    push_request(OP_REPORT, LVL_PRESSED, 32'h0000_00F9);
    push_request(OP_TICK, LVL_PRESSED, 32'h0000_00FA);   // held 251: long press
    push_request(OP_REPORT, LVL_RELEASED, 32'd300);
    push_request(OP_TICK, LVL_PRESSED, 32'd301);
    push_request(OP_REPORT, LVL_PRESSED, 32'd1000);
    push_request(OP_REPORT, LVL_RELEASED, 32'd1050);
    push_request(OP_TICK, LVL_RELEASED, 32'd1200);
    push_request(OP_TICK, LVL_RELEASED, 32'd1201);
    push_request(OP_REPORT, LVL_PRESSED, 32'd2000);
    push_request(OP_REPORT, LVL_RELEASED, 32'd2010);
    push_request(OP_REPORT, LVL_PRESSED, 32'd2020);
    push_request(OP_REPORT, LVL_RELEASED, 32'd2030);
    push_request(OP_REPORT, LVL_PRESSED, 32'd2040);      // press while a double click waits
    push_request(OP_TICK, LVL_RELEASED, 32'd2041);
    push_request(OP_REPORT, LVL_RELEASED, 32'd2050);     // release while idle
    push_request(OP_REPORT, LVL_PRESSED, 32'd3000);
    push_request(OP_REPORT, LVL_RELEASED, 32'd3010);
    push_request(OP_REPORT, LVL_PRESSED, 32'd3020);
    push_request(OP_TICK, LVL_RELEASED, 32'd3271);
    push_request(OP_REPORT, LVL_RELEASED, 32'd3300);
    push_request(OP_TICK, LVL_PRESSED, 32'hFFFF_FFFF);
    btn_level = LVL_RELEASED;
    drain_gestures();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin lp = 16'd0; cg = 16'd0; end
        1: begin lp = 16'hFFFF; cg = 16'hFFFF; end
        2: begin lp = 16'hFFFF; cg = 16'd0; end
        3: begin lp = 16'($urandom_range(1, 64)); cg = 16'($urandom_range(1, 64)); end
        4: begin lp = 16'd0; cg = 16'hFFFF; end
        default: begin
          lp = 16'($urandom_range(100, 1000));
          cg = 16'($urandom_range(50, 600));
        end
      endcase
      write_threshold(REG_LONG_PRESS, lp);
      write_threshold(REG_CLICK_GAP, cg);
      // Odd phases start close to the top so the timestamps wrap.
      if (phase % 2) stamp_clock = 32'hFFFF_FFFF - $urandom_range(0, 3 * 65536);
      else stamp_clock = $urandom();
      sent = req_count;
      while (req_count - sent < ITEMS_PER_PHASE) begin
        src_no_stall = ($urandom_range(0, 3) == 0);
        sink_no_stall <= ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
          send_item(OP_TICK, 1'($urandom_range(0, 1)), $urandom_range(0, 2 * lp + 2));
        end else begin
          play_gesture();
        end
      end
      drain_gestures();
    end

    if (board.errors == 0 && board.gesture_q.size() == 0)
      $display("** button_gesture_classifier: PASSED **");
    else
      $display("** button_gesture_classifier: FAILED **");
    $finish;
  end

endmodule
